// ===== rtl/puk_pkg.sv =====
// Shared types, kind codes and ramp tables for the particle update kernel.
// No dependencies; imported by every module of the block.
package puk_pkg;

  localparam logic [2:0] KIND_STATIC   = 3'd0;
  localparam logic [2:0] KIND_GRAV     = 3'd1;
  localparam logic [2:0] KIND_SLOWGRAV = 3'd2;
  localparam logic [2:0] KIND_FIRE     = 3'd3;
  localparam logic [2:0] KIND_EXPLODE  = 3'd4;
  localparam logic [2:0] KIND_EXPLODE2 = 3'd5;
  localparam logic [2:0] KIND_BLOB     = 3'd6;
  localparam logic [2:0] KIND_BLOB2    = 3'd7;

  localparam logic [11:0] GRAVITY_RESET = 12'd800;
  localparam logic [15:0] RECIP5        = 16'd52429;

  typedef struct packed {
    logic              alive;
    logic [2:0][23:0]  pos;
    logic [2:0][23:0]  vel;
    logic [2:0][40:0]  prod;
    logic [27:0]       gp;
    logic [15:0]       step;
    logic [15:0]       ramp;
    logic [2:0]        kind;
    logic [7:0]        color;
    logic [31:0]       die;
  } s1_t;

  typedef struct packed {
    logic              alive;
    logic [2:0][23:0]  pos;
    logic [2:0][23:0]  vel;
    logic [33:0]       gq;
    logic [15:0]       ramp;
    logic [2:0]        kind;
    logic [7:0]        color;
    logic [31:0]       die;
  } s2_t;

  function automatic logic [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) return 24'h7fffff;
    if (v < -28'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic logic [7:0] ramp_color(input logic [2:0] kind, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (kind)
      KIND_FIRE: begin
        case (idx)
          3'd0: c = 8'h6d;
          3'd1: c = 8'h6b;
          3'd2: c = 8'h06;
          3'd3: c = 8'h05;
          3'd4: c = 8'h04;
          3'd5: c = 8'h03;
          default: c = 8'h00;
        endcase
      end
      KIND_EXPLODE: c = 8'h6f - {4'd0, idx, 1'b0};
      default: begin
        case (idx)
          3'd6: c = 8'h68;
          3'd7: c = 8'h66;
          default: c = 8'h6f - {5'd0, idx};
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/puk_mul_stage.sv =====
// First pipeline stage: velocity by frame time products, gravity product, ramp step.
// Depends on puk_pkg.
module puk_mul_stage import puk_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [247:0] in_data,
  input  logic [2:0]   in_kind,
  input  logic [11:0]  gravity,
  output s1_t          s1
);

  logic [15:0] ft;
  logic [3:0]  mult;
  logic [19:0] stepw;
  logic [31:0] die;
  logic [30:0] now;

  assign ft  = in_data[246:231];
  assign die = in_data[199:168];
  assign now = in_data[230:200];

  always_comb begin
    case (in_kind)
      KIND_FIRE:     mult = 4'd5;
      KIND_EXPLODE:  mult = 4'd10;
      KIND_EXPLODE2: mult = 4'd15;
      default:       mult = 4'd0;
    endcase
    stepw = ft * mult;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.alive <= !($signed(die) < $signed({1'b0, now}));
      for (int i = 0; i < 3; i++) begin
        s1.pos[i]  <= in_data[24*i +: 24];
        s1.vel[i]  <= in_data[72 + 24*i +: 24];
        s1.prod[i] <= 41'($signed(in_data[72 + 24*i +: 24]) * $signed({1'b0, ft}));
      end
      s1.gp    <= ft * gravity;
      s1.step  <= stepw[19:4];
      s1.ramp  <= in_data[159:144];
      s1.kind  <= in_kind;
      s1.color <= in_data[167:160];
      s1.die   <= die;
    end
  end

endmodule

// ===== rtl/puk_move_stage.sv =====
// Second pipeline stage: position move, ramp and colour, velocity growth or decay.
// Depends on puk_pkg.
module puk_move_stage import puk_pkg::*; (
  input  logic clk,
  input  logic en,
  input  s1_t  s1,
  output s2_t  s2
);

  logic [2:0][23:0] pos_n, vel_n;
  logic [16:0]      ramp_sum;
  logic [15:0]      ramp_n;
  logic [7:0]       color_n;
  logic [31:0]      die_n;
  logic             has_ramp;
  logic [3:0]       limit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_n[i] = sat24(28'($signed(s1.pos[i])) + 28'($signed(s1.prod[i]) >>> 16));
      case (s1.kind)
        KIND_EXPLODE, KIND_BLOB:
          vel_n[i] = sat24(28'($signed(s1.vel[i])) + 28'($signed(s1.prod[i]) >>> 14));
        KIND_EXPLODE2:
          vel_n[i] = sat24(28'($signed(s1.vel[i])) - 28'($signed(s1.prod[i]) >>> 16));
        KIND_BLOB2:
          vel_n[i] = (i == 2) ? s1.vel[i] :
                     sat24(28'($signed(s1.vel[i])) - 28'($signed(s1.prod[i]) >>> 14));
        default: vel_n[i] = s1.vel[i];
      endcase
    end
    has_ramp = (s1.kind == KIND_FIRE) || (s1.kind == KIND_EXPLODE) ||
               (s1.kind == KIND_EXPLODE2);
    limit    = (s1.kind == KIND_FIRE) ? 4'd6 : 4'd8;
    ramp_sum = {1'b0, s1.ramp} + {1'b0, s1.step};
    ramp_n   = s1.ramp;
    color_n  = s1.color;
    die_n    = s1.die;
    if (has_ramp) begin
      ramp_n = ramp_sum[16] ? 16'hffff : ramp_sum[15:0];
      if (ramp_n[15:12] >= limit) die_n = 32'hffffffff;
      else color_n = ramp_color(s1.kind, ramp_n[14:12]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.alive <= s1.alive;
      s2.pos   <= s1.alive ? pos_n : s1.pos;
      s2.vel   <= s1.alive ? vel_n : s1.vel;
      s2.ramp  <= s1.alive ? ramp_n : s1.ramp;
      s2.color <= s1.alive ? color_n : s1.color;
      s2.die   <= s1.alive ? die_n : s1.die;
      s2.kind  <= s1.kind;
      s2.gq    <= s1.gp[27:10] * RECIP5;
    end
  end

endmodule

// ===== rtl/particle_update_kernel.sv =====
// Top level of the particle update kernel: handshake, gravity register, last stage.
// Depends on puk_pkg, puk_mul_stage and puk_move_stage.
//
//  channel | signals                               | role
//  s_      | s_tvalid s_tready s_tdata s_tuser     | particle item in
//  m_      | m_tvalid m_tready m_tdata m_tuser     | updated item out
//  apb     | psel penable pwrite paddr pwdata ...  | gravity register at 0x0
//
// Three register stages; one item per cycle while no stall on m_tready holds them.
// Reset clears the valid bits and sets gravity to 800.
// A stall on m_tready freezes all stages together and drops s_tready.
module particle_update_kernel import puk_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [247:0] s_tdata,  // pos_x,pos_y,pos_z,vel_x,vel_y,vel_z,ramp_pos,color_in,
                                 // die_time,now,frame_time,pad
  input  logic [2:0]   s_tuser,  // particle_kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,  // new_pos_x,y,z,new_vel_x,y,z,new_ramp,new_color,new_die_time
  output logic         m_tuser,  // alive
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [11:0] gravity;
  logic [2:0]  vld;
  logic        en;
  s1_t         s1;
  s2_t         s2;
  logic [15:0] g;
  logic [23:0] vz_n;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {20'd0, gravity} : 32'd0;
  assign en       = !vld[2] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GRAVITY_RESET;
      vld     <= 3'b000;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) gravity <= pwdata[11:0];
      if (en) vld <= {vld[1:0], s_tvalid};
    end
  end

  puk_mul_stage u_mul (
    .clk(clk), .en(en), .in_data(s_tdata), .in_kind(s_tuser), .gravity(gravity), .s1(s1)
  );

  puk_move_stage u_move (.clk(clk), .en(en), .s1(s1), .s2(s2));

  always_comb begin
    g = s2.gq[33:18];
    case (s2.kind)
      KIND_STATIC: vz_n = s2.vel[2];
      KIND_FIRE:   vz_n = sat24(28'($signed(s2.vel[2])) + 28'({12'd0, g}));
      default:     vz_n = sat24(28'($signed(s2.vel[2])) - 28'({12'd0, g}));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= s2.alive;
      m_tdata <= {s2.die, s2.color, s2.ramp, (s2.alive ? vz_n : s2.vel[2]),
                  s2.vel[1], s2.vel[0], s2.pos[2], s2.pos[1], s2.pos[0]};
    end
  end

endmodule
